>>> design/lkvc_pkg.sv
`default_nettype none
package lkvc_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 16;

	localparam int CAP_W   = 5;
	localparam int KEY_W   = 16;
	localparam int VALUE_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		logic hit;
		logic evicted;
	} lkvc_stat_t;

endpackage
`default_nettype wire

>>> design/lkvc_ram.sv
`default_nettype none
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/lkvc_dir.sv
`default_nettype none
module lkvc_dir
	import lkvc_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [CAP_W-1:0]    capacity,
	input  wire logic                fire,
	input  wire op_t                 op,
	input  wire logic [KEY_BITS-1:0] key,
	output lkvc_stat_t               stat,
	output logic                     ram_we,
	output logic      [IW-1:0]       ram_idx,
	output logic      [KEY_BITS-1:0] evicted_key
);

	localparam int RW   = IW;
	localparam int UW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (UW > CAP_W) ? UW : CAP_W;

	logic [KEY_BITS-1:0] key_q   [ENTRIES];
	logic [RW-1:0]       rank_q  [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [UW-1:0]       used_q;

	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] victim_vec;
	logic [ENTRIES-1:0] inc_vec;
	logic [IW-1:0]      hit_idx;
	logic [IW-1:0]      victim_idx;
	logic [IW-1:0]      free_idx;
	logic [RW-1:0]      sel_rank;
	logic [UW-1:0]      last_rank;
	logic [CMPW-1:0]    used_x;
	logic [CMPW-1:0]    cap_x;
	logic               hit;
	logic               found;
	logic               is_put;
	logic               room;
	logic               fill;
	logic               evict;

	assign is_put    = (op == OP_PUT);
	assign last_rank = used_q - 1'b1;
	assign used_x    = CMPW'(used_q);
	assign cap_x     = CMPW'(capacity);

	// zero capacity acts as one
	assign room = (used_q != UW'(ENTRIES)) &&
		((used_x < cap_x) || ((capacity == '0) && (used_q == '0)));

	// valid ranks are 0 .. used-1, so the least recent one has rank used-1
	always_comb begin
		match_vec   = '0;
		victim_vec  = '0;
		hit_idx     = '0;
		victim_idx  = '0;
		free_idx    = '0;
		sel_rank    = '0;
		evicted_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i]  = valid_q[i] && (key_q[i] == key);
			victim_vec[i] = valid_q[i] && (UW'(rank_q[i]) == last_rank);
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_idx  = hit_idx | IW'(i);
			end
			if (victim_vec[i]) begin
				victim_idx  = victim_idx | IW'(i);
				evicted_key = evicted_key | key_q[i];
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
		hit   = |match_vec;
		found = |victim_vec;
		fill  = is_put && !hit && room;
		evict = is_put && !hit && !room && found;
		for (int i = 0; i < ENTRIES; i++) begin
			if ((hit && match_vec[i]) || (evict && victim_vec[i])) begin
				sel_rank = sel_rank | rank_q[i];
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			inc_vec[i] = valid_q[i] && (fill || ((hit || evict) && (rank_q[i] < sel_rank)));
		end
		if (!evict) begin
			evicted_key = '0;
		end
	end

	always_comb begin
		priority if (hit) begin
			ram_idx = hit_idx;
		end else if (fill) begin
			ram_idx = free_idx;
		end else begin
			ram_idx = victim_idx;
		end
	end

	assign ram_we       = fire && is_put && (hit || fill || evict);
	assign stat.hit     = hit;
	assign stat.evicted = evict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (fire && (hit || fill || evict)) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IW'(i) == ram_idx) begin
					rank_q[i] <= '0;
				end else if (inc_vec[i]) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (fill) begin
				valid_q[free_idx] <= 1'b1;
				used_q            <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (fill || evict)) begin
			key_q[ram_idx] <= key;
		end
	end

	a_used_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(used_q))
		else $error("used count differs from number of valid entries");

	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("key present in more than one entry");

	a_fill_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fill |=> used_q == $past(used_q) + 1'b1)
		else $error("fill did not advance used count");

	a_evict_needs_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != '0) |-> $onehot(victim_vec))
		else $error("no unique least recent entry");

endmodule
`default_nettype wire

>>> design/lru_key_value_cache.sv
// Fully associative LRU key-value cache, one access per item.
// m_tvalid presents the result once the item accepted into the input register
// has gone through lookup/update into the output register.
// Throughput: one item per cycle while m_tready does not stall the output; tag
// compare, rank update and value RAM port all complete in the lookup cycle.
// Reset: arst_n clears valid bits, ranks, used count and sets capacity to 16.
`default_nettype none
module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] cfg_data,   // capacity
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [47:0]      s_tdata,    // key[15:0], value[47:16]
	input  wire logic [0:0]       s_tuser,    // op
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [55:0]      m_tdata     // hit, read_value, evicted, evicted_key
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [CAP_W-1:0]    capacity_q;
	logic                valid_s1;
	op_t                 op_s1;
	logic [KEY_BITS-1:0] key_s1;
	logic [VALUE_W-1:0]  value_s1;
	logic [KEY_BITS-1:0] key_in;

	logic                valid_s2;
	logic                hit_s2;
	logic                rdsel_s2;
	logic                evicted_s2;
	logic [KEY_W-1:0]    evkey_s2;

	logic                fire;
	lkvc_stat_t          stat;
	logic                ram_we;
	logic [IW-1:0]       ram_idx;
	logic [KEY_BITS-1:0] evicted_key;
	logic [KEY_W-1:0]    evkey_out;
	logic [VALUE_W-1:0]  rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	generate
		if (KEY_BITS <= KEY_W) begin : g_key_narrow
			assign key_in    = s_tdata[KEY_BITS-1:0];
			assign evkey_out = KEY_W'(evicted_key);
		end else begin : g_key_wide
			assign key_in    = {{(KEY_BITS - KEY_W){1'b0}}, s_tdata[KEY_W-1:0]};
			assign evkey_out = evicted_key[KEY_W-1:0];
		end
	endgenerate

	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= op_t'(s_tuser[0]);
			key_s1   <= key_in;
			value_s1 <= s_tdata[47:16];
		end
	end

	lkvc_dir #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_dir (
		.clk         (clk),
		.arst_n      (arst_n),
		.capacity    (capacity_q),
		.fire        (fire),
		.op          (op_s1),
		.key         (key_s1),
		.stat        (stat),
		.ram_we      (ram_we),
		.ram_idx     (ram_idx),
		.evicted_key (evicted_key)
	);

	// read data registers together with the output stage and holds while stalled
	lkvc_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (ENTRIES)
	) u_value_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_idx),
		.wdata (value_s1),
		.re    (fire),
		.raddr (ram_idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_s2     <= stat.hit;
			rdsel_s2   <= stat.hit && (op_s1 == OP_GET);
			evicted_s2 <= stat.evicted;
			evkey_s2   <= evkey_out;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, evkey_s2, evicted_s2,
		(rdsel_s2 ? rdata : {VALUE_W{1'b0}}), hit_s2};

endmodule
`default_nettype wire
